>>> rtl/core/puct_pkg.sv
// Shared types, constants and the saturation helper function of the PUCT action selection block.
package puct_pkg;

   localparam int SLOT_COUNT = 64;
   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int VALUE_FRAC_BITS = 16;
   localparam int UN_W = 24 + VALUE_FRAC_BITS;
   localparam int DEN_W = 33;

   localparam logic signed [31:0] MAX_RESET =
      32'(-((64'sd99999 <<< VALUE_FRAC_BITS) / 64'sd10));

   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_LOAD   = 3'd1,
      OP_NOISE  = 3'd2,
      OP_SELECT = 3'd3,
      OP_BACKUP = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      CSR_EXPLORE = 3'd0,
      CSR_VLOSS   = 3'd1,
      CSR_GAMES   = 3'd2,
      CSR_NOISE   = 3'd3,
      CSR_ACTIONS = 3'd4
   } csr_index_type;

   typedef enum logic [4:0] {
      S_IDLE, S_CLEAR, S_LOAD, S_N_RD, S_N_MUL, S_N_WR,
      S_SQ_GO, S_SQ_WAIT, S_RD, S_CP, S_UN, S_QW, S_UGO, S_UW, S_CMP,
      S_SEL_RD, S_SEL_WR, S_B_RD, S_B_WR, S_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic is_sqrt;
   } alu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_stat_type;

   function automatic logic signed [31:0] sat_s32(input logic signed [41:0] v);
      logic signed [31:0] r;
      if (v > 42'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -42'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = 32'(v);
      end
      return r;
   endfunction

endpackage

>>> rtl/core/puct_if.sv
// Handshake channel interfaces for requests, responses and register writes.
interface puct_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [5:0]  action_index;
   logic [15:0] prior_in;
   logic [15:0] noise_in;
   logic signed [31:0] leaf_value;
   logic [31:0] move_id;
   modport source (output valid, opcode, action_index, prior_in, noise_in, leaf_value,
                   move_id, input ready);
   modport sink (input valid, opcode, action_index, prior_in, noise_in, leaf_value,
                 move_id, output ready);
endinterface

interface puct_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  selected_index;
   logic [31:0] visit_total;
   logic signed [31:0] best_value;
   logic [5:0]  best_index;
   logic        best_valid;
   logic [31:0] best_action_id;
   logic        count_error;
   modport source (output valid, selected_index, visit_total, best_value, best_index,
                   best_valid, best_action_id, count_error, input ready);
   modport sink (input valid, selected_index, visit_total, best_value, best_index,
                 best_valid, best_action_id, count_error, output ready);
endinterface

interface puct_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/puct_ram.sv
// Generic single-write, single-read RAM with registered read data.
module puct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule

>>> rtl/core/puct_alu.sv
// Shared iterative unit: restoring divider and integer square root, one bit per cycle.
module puct_alu (
   input  logic                      clock,
   input  logic                      reset,
   input  puct_pkg::alu_cmd_type     cmd,
   input  logic [63:0]               opa,
   input  logic [puct_pkg::DEN_W-1:0] opb,
   output puct_pkg::alu_stat_type    stat,
   output logic [puct_pkg::UN_W-1:0] result
);
   import puct_pkg::*;

   logic        run_ff, run_in, sq_ff, sq_in, done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] a_ff, a_in, r_ff, r_in, b_ff, b_in;
   logic [63:0] trial;
   logic [DEN_W:0] rs, dv;

   always_comb begin
      run_in  = run_ff;
      sq_in   = sq_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      r_in    = r_ff;
      b_in    = b_ff;
      trial   = r_ff + b_ff;
      rs      = {r_ff[DEN_W-1:0], a_ff[UN_W-1]};
      dv      = b_ff[DEN_W:0];
      if (cmd.start) begin
         run_in = 1'b1;
         sq_in  = cmd.is_sqrt;
         a_in   = opa;
         r_in   = '0;
         if (cmd.is_sqrt) begin
            b_in   = 64'h4000_0000_0000_0000;
            cnt_in = 6'd31;
         end else begin
            b_in   = 64'(opb);
            cnt_in = 6'(UN_W - 1);
         end
      end else if (run_ff) begin
         if (sq_ff) begin
            if (a_ff >= trial) begin
               a_in = a_ff - trial;
               r_in = (r_ff >> 1) + b_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            b_in = b_ff >> 2;
         end else begin
            if (rs >= dv) begin
               r_in = 64'(rs - dv);
               a_in = {a_ff[62:0], 1'b1};
            end else begin
               r_in = 64'(rs);
               a_in = {a_ff[62:0], 1'b0};
            end
         end
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      sq_ff  <= sq_in;
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      r_ff   <= r_in;
      b_ff   <= b_in;
   end

   assign stat.busy = run_ff;
   assign stat.done = done_ff;
   assign result = sq_ff ? UN_W'(r_ff[31:0]) : a_ff[UN_W-1:0];
endmodule

>>> rtl/core/puct_action_select_top.sv
// Top level of the PUCT action selection engine: sequencer, statistics tables and datapath.
// One transaction is taken at a time. Select first takes the square root of the visit
// count, then works through each action in use with up to two 40-step divisions on the
// shared bit-serial unit, and ends with a table update. A finished response waits in an
// output register while the next transaction is taken.
module puct_action_select_top (
   input logic     clock,
   input logic     reset,
   puct_req_if.sink   req_ch,
   puct_rsp_if.source rsp_ch,
   puct_csr_if.sink   csr_ch
);
   import puct_pkg::*;

   state_type state_ff, state_in;

   logic [23:0] ew_ff;
   logic signed [31:0] vl_ff;
   logic [7:0]  g_ff;
   logic [16:0] nw_ff;
   logic [6:0]  aiu_ff;

   logic [IDX_W-1:0] idx_ff;
   logic [15:0] pin_ff, nin_ff;
   logic signed [31:0] nv_ff;
   logic [31:0] aid_ff;
   logic signed [40:0] loss_ff;

   logic [31:0] root_ff, root_in;
   logic [IDX_W-1:0] i_ff, i_in, bidx_ff, bidx_in;
   logic signed [31:0] c_ff, c_in, t_ff, t_in, q_ff, q_in, u_ff, u_in;
   logic [23:0] cp_ff, cp_in;
   logic [UN_W-1:0] un_ff, un_in;
   logic signed [32:0] best_ff, best_in;
   logic [32:0] acc_ff, acc_in;

   logic [31:0] visit_ff, visit_in;
   logic signed [31:0] maxv_ff, maxv_in;
   logic [IDX_W-1:0] maxslot_ff, maxslot_in, sel_ff, sel_in;
   logic        maxseen_ff, maxseen_in, err_ff, err_in;
   logic [31:0] maxid_ff, maxid_in;
   logic [SLOT_COUNT-1:0] cv_ff, cv_in;
   logic        rdv_ff;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [IDX_W-1:0] o_sel_ff, o_slot_ff;
   logic [31:0] o_visit_ff, o_id_ff;
   logic signed [31:0] o_maxv_ff;
   logic        o_seen_ff, o_err_ff;

   logic        req_fire, rsp_free;
   logic [IDX_W-1:0] rd_addr, wr_addr, n_last;
   logic        prior_we, stat_we;
   logic [15:0] prior_wdata, prior_rdata;
   logic [31:0] cnt_rdata, val_rdata;
   logic signed [31:0] cnt_wdata, val_wdata, c_rd, t_rd;
   alu_cmd_type alu_cmd;
   alu_stat_type alu_stat;
   logic [63:0] alu_opa;
   logic [DEN_W-1:0] alu_opb;
   logic [UN_W-1:0] alu_res;

   logic [16:0] r_eff;
   logic [33:0] mix;
   logic [31:0] tmag, cmag;
   logic signed [32:0] d;
   logic [DEN_W-1:0] dmag;
   logic signed [41:0] qs, us, cb, vsum;
   logic signed [32:0] score;
   logic signed [9:0] gm1;
   logic signed [33:0] vdiff;
   logic [32:0] vadd;
   logic [55:0] unprod;
   logic [39:0] cpprod;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      if (aiu_ff >= 7'(SLOT_COUNT)) begin
         n_last = IDX_W'(SLOT_COUNT - 1);
      end else if (aiu_ff == '0) begin
         n_last = '0;
      end else begin
         n_last = IDX_W'(aiu_ff - 7'd1);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (op_type'(req_ch.opcode))
                  OP_CLEAR:  state_in = S_CLEAR;
                  OP_LOAD:   state_in = S_LOAD;
                  OP_NOISE:  state_in = S_N_RD;
                  OP_SELECT: state_in = S_SQ_GO;
                  OP_BACKUP: state_in = S_B_RD;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_CLEAR, S_LOAD: state_in = S_DONE;
         S_N_RD:   state_in = S_N_MUL;
         S_N_MUL:  state_in = S_N_WR;
         S_N_WR:   state_in = S_DONE;
         S_SQ_GO:  state_in = S_SQ_WAIT;
         S_SQ_WAIT: begin
            if (alu_stat.done) begin
               state_in = S_RD;
            end
         end
         S_RD:     state_in = S_CP;
         S_CP:     state_in = S_UN;
         S_UN:     state_in = S_QW;
         S_QW: begin
            if (c_ff == '0 || alu_stat.done) begin
               state_in = S_UGO;
            end
         end
         S_UGO:    state_in = S_UW;
         S_UW: begin
            if (c_ff == -32'sd1 || alu_stat.done) begin
               state_in = S_CMP;
            end
         end
         S_CMP:    state_in = (i_ff == n_last) ? S_SEL_RD : S_RD;
         S_SEL_RD: state_in = S_SEL_WR;
         S_SEL_WR: state_in = S_DONE;
         S_B_RD:   state_in = S_B_WR;
         S_B_WR:   state_in = S_DONE;
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      req_ch.ready    = (state_ff == S_IDLE);
      csr_ch.ready    = 1'b1;
      alu_cmd.start   = 1'b0;
      alu_cmd.is_sqrt = 1'b0;
      prior_we        = 1'b0;
      stat_we         = 1'b0;
      rd_addr         = idx_ff;
      wr_addr         = idx_ff;
      case (state_ff)
         S_LOAD, S_N_WR: prior_we = 1'b1;
         S_SQ_GO: begin
            alu_cmd.start   = 1'b1;
            alu_cmd.is_sqrt = 1'b1;
         end
         S_RD:     rd_addr = i_ff;
         S_UN:     alu_cmd.start = (c_ff != '0);
         S_UGO:    alu_cmd.start = (c_ff != -32'sd1);
         S_SEL_RD: rd_addr = bidx_ff;
         S_SEL_WR: begin
            stat_we = 1'b1;
            wr_addr = bidx_ff;
         end
         S_B_WR:   stat_we = 1'b1;
         default: begin
         end
      endcase
   end

   // Datapath.
   always_comb begin
      root_in = root_ff;   i_in = i_ff;       bidx_in = bidx_ff;
      c_in = c_ff;         t_in = t_ff;       q_in = q_ff;       u_in = u_ff;
      cp_in = cp_ff;       un_in = un_ff;     best_in = best_ff; acc_in = acc_ff;
      visit_in = visit_ff; maxv_in = maxv_ff; maxslot_in = maxslot_ff;
      maxseen_in = maxseen_ff; maxid_in = maxid_ff; sel_in = sel_ff; err_in = err_ff;
      cv_in = cv_ff;       rsp_valid_in = rsp_valid_ff;

      c_rd  = rdv_ff ? $signed(cnt_rdata) : 32'sd0;
      t_rd  = rdv_ff ? $signed(val_rdata) : 32'sd0;
      r_eff = (nw_ff > 17'd65536) ? 17'd65536 : nw_ff;
      mix   = 34'(acc_ff) + 34'(nin_ff) * 34'(r_eff) + 34'd32768;
      prior_wdata = (state_ff == S_LOAD) ? pin_ff : mix[31:16];

      tmag = t_ff[31] ? 32'(-t_ff) : 32'(t_ff);
      cmag = c_ff[31] ? 32'(-c_ff) : 32'(c_ff);
      d    = 33'(c_ff) + 33'sd1;
      dmag = d[32] ? DEN_W'(-d) : DEN_W'(d);
      qs   = (t_ff[31] ^ c_ff[31]) ? -$signed({2'b00, alu_res}) : $signed({2'b00, alu_res});
      us   = d[32] ? -$signed({2'b00, alu_res}) : $signed({2'b00, alu_res});
      score = 33'(q_ff) + 33'(u_ff);
      cpprod = 40'(ew_ff) * 40'(prior_rdata);
      unprod = 56'(cp_ff) * 56'(root_ff);

      gm1   = $signed({2'b00, g_ff}) - 10'sd1;
      vadd  = 33'(visit_ff) + 33'(g_ff);
      vdiff = $signed({2'b00, visit_ff}) - 34'(gm1);
      cb    = 42'(c_rd);
      vsum  = 42'(t_rd);
      cnt_wdata = c_rd;
      val_wdata = t_rd;

      alu_opa = {visit_ff, 32'd0};
      alu_opb = DEN_W'(cmag);
      if (state_ff == S_UGO) begin
         alu_opa = 64'(un_ff);
         alu_opb = dmag;
      end else if (state_ff == S_UN) begin
         alu_opa = 64'(tmag);
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               sel_in = '0;
               err_in = 1'b0;
            end
         end
         S_CLEAR: begin
            cv_in = '0;
            visit_in = '0;
            maxv_in = MAX_RESET;
            maxslot_in = '0;
            maxseen_in = 1'b0;
            maxid_in = '0;
         end
         S_N_MUL:   acc_in = 33'(prior_rdata) * 33'(17'd65536 - r_eff);
         S_SQ_WAIT: begin
            root_in = alu_res[31:0];
            i_in = '0;
         end
         S_CP: begin
            c_in = c_rd;
            t_in = t_rd;
            cp_in = cpprod[39:16];
         end
         S_UN:      un_in = UN_W'(unprod >> (32 - VALUE_FRAC_BITS));
         S_QW: begin
            if (c_ff == '0) begin
               q_in = (t_ff > 0) ? 32'sh7FFFFFFF : ((t_ff < 0) ? 32'sh80000000 : 32'sd0);
            end else begin
               q_in = sat_s32(qs);
            end
         end
         S_UW: begin
            if (c_ff == -32'sd1) begin
               u_in = (un_ff != '0) ? 32'sh7FFFFFFF : 32'sd0;
            end else begin
               u_in = sat_s32(us);
            end
         end
         S_CMP: begin
            if (i_ff == '0 || score > best_ff) begin
               best_in = score;
               bidx_in = i_ff;
            end
            i_in = i_ff + 1'b1;
         end
         S_SEL_WR: begin
            cnt_wdata = sat_s32(42'(c_rd) + $signed({34'd0, g_ff}));
            val_wdata = sat_s32(42'(t_rd) - 42'(loss_ff));
            cv_in[bidx_ff] = 1'b1;
            visit_in = vadd[32] ? 32'hFFFF_FFFF : vadd[31:0];
            sel_in = bidx_ff;
         end
         S_B_WR: begin
            cb = 42'(c_rd) - 42'(gm1);
            cnt_wdata = sat_s32(cb);
            err_in = (cnt_wdata < 32'sd1);
            vsum = 42'(t_rd) + 42'(loss_ff) + 42'(nv_ff);
            val_wdata = sat_s32(vsum);
            cv_in[idx_ff] = 1'b1;
            if (nv_ff > maxv_ff) begin
               maxv_in = nv_ff;
               maxslot_in = idx_ff;
               maxid_in = aid_ff;
               maxseen_in = 1'b1;
            end
            if (vdiff < 0) begin
               visit_in = '0;
            end else if (vdiff > 34'sh0_FFFF_FFFF) begin
               visit_in = 32'hFFFF_FFFF;
            end else begin
               visit_in = vdiff[31:0];
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         ew_ff   <= 24'd65536;
         vl_ff   <= 32'sd65536;
         g_ff    <= 8'd1;
         nw_ff   <= 17'd16384;
         aiu_ff  <= 7'd64;
         cv_ff   <= '0;
         visit_ff <= '0;
         maxv_ff  <= MAX_RESET;
         maxslot_ff <= '0;
         maxseen_ff <= 1'b0;
         maxid_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cv_ff      <= cv_in;
         visit_ff   <= visit_in;
         maxv_ff    <= maxv_in;
         maxslot_ff <= maxslot_in;
         maxseen_ff <= maxseen_in;
         maxid_ff   <= maxid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_index_type'(csr_ch.index))
               CSR_EXPLORE: ew_ff  <= csr_ch.data[23:0];
               CSR_VLOSS:   vl_ff  <= $signed(csr_ch.data);
               CSR_GAMES:   g_ff   <= csr_ch.data[7:0];
               CSR_NOISE:   nw_ff  <= csr_ch.data[16:0];
               CSR_ACTIONS: aiu_ff <= csr_ch.data[6:0];
               default: begin
               end
            endcase
         end
      end
      if (req_fire) begin
         idx_ff  <= req_ch.action_index;
         pin_ff  <= req_ch.prior_in;
         nin_ff  <= req_ch.noise_in;
         nv_ff   <= req_ch.leaf_value;
         aid_ff  <= req_ch.move_id;
         loss_ff <= 41'($signed({1'b0, g_ff})) * 41'(vl_ff);
      end
      root_ff <= root_in;  i_ff <= i_in;     bidx_ff <= bidx_in;
      c_ff <= c_in;        t_ff <= t_in;     q_ff <= q_in;     u_ff <= u_in;
      cp_ff <= cp_in;      un_ff <= un_in;   best_ff <= best_in; acc_ff <= acc_in;
      sel_ff <= sel_in;    err_ff <= err_in;
      rdv_ff <= cv_ff[rd_addr];
      if (state_ff == S_DONE && rsp_free) begin
         o_sel_ff   <= sel_ff;
         o_visit_ff <= visit_ff;
         o_maxv_ff  <= maxv_ff;
         o_slot_ff  <= maxslot_ff;
         o_seen_ff  <= maxseen_ff;
         o_id_ff    <= maxid_ff;
         o_err_ff   <= err_ff;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.selected_index = o_sel_ff;
   assign rsp_ch.visit_total    = o_visit_ff;
   assign rsp_ch.best_value     = o_maxv_ff;
   assign rsp_ch.best_index     = o_slot_ff;
   assign rsp_ch.best_valid     = o_seen_ff;
   assign rsp_ch.best_action_id = o_id_ff;
   assign rsp_ch.count_error    = o_err_ff;

   puct_ram #(.WIDTH(16), .DEPTH(SLOT_COUNT)) u_prior_ram (
      .clock(clock), .we(prior_we), .waddr(wr_addr), .wdata(prior_wdata),
      .raddr(rd_addr), .rdata(prior_rdata)
   );

   puct_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_count_ram (
      .clock(clock), .we(stat_we), .waddr(wr_addr), .wdata(32'(cnt_wdata)),
      .raddr(rd_addr), .rdata(cnt_rdata)
   );

   puct_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_value_ram (
      .clock(clock), .we(stat_we), .waddr(wr_addr), .wdata(32'(val_wdata)),
      .raddr(rd_addr), .rdata(val_rdata)
   );

   puct_alu u_alu (
      .clock(clock), .reset(reset), .cmd(alu_cmd), .opa(alu_opa), .opb(alu_opb),
      .stat(alu_stat), .result(alu_res)
   );

   // The shared unit is never restarted while it is still iterating.
   assert property (@(posedge clock) disable iff (reset) alu_cmd.start |-> !alu_stat.busy)
      else $error("shared unit started while busy");

   // A select never lowers the node visit count.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SEL_WR |=> visit_ff >= $past(visit_ff))
      else $error("visit count fell on select");

   // A finished transaction with a free output slot is presented on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("response not presented");

   // Until a maximum is recorded the running maximum keeps its reset value.
   assert property (@(posedge clock) disable iff (reset) !maxseen_ff |-> maxv_ff == MAX_RESET)
      else $error("maximum changed without being recorded");
endmodule
